// ----- hw/rtl/semaphore_table_unit_top_assert.svh -----
// Assertion helpers for the semaphore table RTL.
// Both macros expect signals named clk and arst_n in the module that uses them.
`ifndef SEMAPHORE_TABLE_UNIT_TOP_ASSERT_SVH
`define SEMAPHORE_TABLE_UNIT_TOP_ASSERT_SVH

// A property checked at every clock edge outside reset.
`define STU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another condition in the next cycle.
`define STU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hw/rtl/stu_pkg.sv -----
`default_nettype none
package stu_pkg;

	localparam int unsigned NUM_SEMS_DEF = 16;
	localparam int unsigned ID_W = 6;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FIFO_DEPTH = 2;
	localparam logic [CNT_W-1:0] COUNT_LIMIT_RST = 8'd255;
	localparam logic [CNT_W-1:0] BINARY_MAX = 8'd1;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_WAIT    = 2'd1,
		OP_POST    = 2'd2,
		OP_DESTROY = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_ERR   = 2'd1,
		ST_BLOCK = 2'd2
	} status_t;

	// A request after classification in the front end.
	typedef struct packed {
		op_t              op;
		logic             sem_kind;
		logic [ID_W-1:0]  sem_id;
		logic [CNT_W-1:0] init;
		logic             id_ok;
		logic             init_ok;
	} stu_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/stu_ram.sv -----
`default_nettype none
module stu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/stu_fifo.sv -----
`default_nettype none
module stu_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire stu_pkg::stu_req_t push_req,
	output logic                   full,
	input  wire logic              pop,
	output logic                   valid,
	output stu_pkg::stu_req_t      pop_req
);
	import stu_pkg::*;

	localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [AW:0] DEPTH_C = (AW + 1)'(FIFO_DEPTH);
	localparam logic [AW-1:0] LAST_C = AW'(FIFO_DEPTH - 1);

	stu_req_t        entry_q [FIFO_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full = (count_q == DEPTH_C);
	assign valid = (count_q != '0);
	assign pop_req = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (AW + 1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (AW + 1)'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/stu_front.sv -----
`default_nettype none
module stu_front #(
	parameter int unsigned NUM_SEMS = stu_pkg::NUM_SEMS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [stu_pkg::CNT_W-1:0]  count_limit,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 operation,
	input  wire logic                       sem_kind,
	input  wire logic [stu_pkg::ID_W-1:0]   sem_id,
	input  wire logic [stu_pkg::CNT_W-1:0]  initial_count,
	output logic                            push,
	output stu_pkg::stu_req_t               push_req,
	input  wire logic                       full
);
	import stu_pkg::*;

	localparam logic [ID_W:0] NUM_SEMS_C = (ID_W + 1)'(NUM_SEMS);

	logic     fr_valid_s1;
	stu_req_t fr_req_s1;
	stu_req_t req_cls;
	logic     accept;

	// Range and initial count checks are settled here, so the back end only
	// looks at the tables.
	always_comb begin
		req_cls.op = op_t'(operation);
		req_cls.sem_kind = sem_kind;
		req_cls.sem_id = sem_id;
		req_cls.init = initial_count;
		req_cls.id_ok = ({1'b0, sem_id} < NUM_SEMS_C);
		req_cls.init_ok = sem_kind ? (initial_count <= count_limit)
		                           : (initial_count <= BINARY_MAX);
	end

	assign in_stall = fr_valid_s1 && full;
	assign accept = in_valid && !in_stall;
	assign push = fr_valid_s1 && !full;
	assign push_req = fr_req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_s1 <= 1'b0;
		end else if (accept) begin
			fr_valid_s1 <= 1'b1;
		end else if (push) begin
			fr_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_req_s1 <= req_cls;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/stu_back.sv -----
`default_nettype none
`include "semaphore_table_unit_top_assert.svh"
module stu_back #(
	parameter int unsigned NUM_SEMS = stu_pkg::NUM_SEMS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [stu_pkg::CNT_W-1:0]    count_limit,
	input  wire logic                         q_valid,
	input  wire stu_pkg::stu_req_t            q_req,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [stu_pkg::STATUS_W-1:0]      status,
	output logic [stu_pkg::ID_W-1:0]          allocated_index
);
	import stu_pkg::*;

	localparam int unsigned IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int unsigned ADDR_W = IDX_W + 1;
	localparam int unsigned RAM_DEPTH = 1 << ADDR_W;

	logic [NUM_SEMS-1:0] bin_used_q;
	logic [NUM_SEMS-1:0] cnt_used_q;

	logic             bk_valid_s1;
	stu_req_t         bk_req_s1;
	logic             byp_s1;
	logic [CNT_W-1:0] byp_data_s1;

	logic             out_valid_q;
	status_t          status_q;
	logic [ID_W-1:0]  index_q;

	logic [ADDR_W-1:0] raddr;
	logic [CNT_W-1:0]  ram_rdata;
	logic              ram_we;

	logic [IDX_W-1:0]    idx_s1;
	logic [NUM_SEMS-1:0] sel_used;
	logic                ent_ok;
	logic                free_found;
	logic [IDX_W-1:0]    free_idx;
	logic [CNT_W-1:0]    val;
	logic                adv;

	status_t           st;
	logic [ID_W-1:0]   idx_out;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CNT_W-1:0]  wdata;
	logic              set_en;
	logic              clr_en;
	logic [IDX_W-1:0]  flag_idx;

	assign adv = bk_valid_s1 && (!out_valid_q || !out_stall);
	assign q_pop = q_valid && (!bk_valid_s1 || adv);
	assign raddr = {q_req.sem_kind, q_req.sem_id[IDX_W-1:0]};
	assign ram_we = adv && we;

	stu_ram #(
		.WIDTH(CNT_W),
		.DEPTH(RAM_DEPTH)
	) u_vals (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (q_pop),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign idx_s1 = bk_req_s1.sem_id[IDX_W-1:0];
	assign sel_used = bk_req_s1.sem_kind ? cnt_used_q : bin_used_q;
	assign ent_ok = bk_req_s1.id_ok && sel_used[idx_s1];
	assign val = byp_s1 ? byp_data_s1 : ram_rdata;

	// Lowest free entry of the addressed table.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!sel_used[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		st = ST_ERR;
		idx_out = '0;
		we = 1'b0;
		waddr = {bk_req_s1.sem_kind, idx_s1};
		wdata = val;
		set_en = 1'b0;
		clr_en = 1'b0;
		flag_idx = idx_s1;
		unique case (bk_req_s1.op)
			OP_CREATE: begin
				if (bk_req_s1.init_ok && free_found) begin
					st = ST_OK;
					idx_out = ID_W'(free_idx);
					we = 1'b1;
					waddr = {bk_req_s1.sem_kind, free_idx};
					wdata = bk_req_s1.init;
					set_en = 1'b1;
					flag_idx = free_idx;
				end
			end
			OP_WAIT: begin
				if (ent_ok) begin
					if (val != '0) begin
						st = ST_OK;
						we = 1'b1;
						wdata = CNT_W'(val - 1'b1);
					end else begin
						st = ST_BLOCK;
					end
				end
			end
			OP_POST: begin
				if (ent_ok) begin
					if (!bk_req_s1.sem_kind) begin
						st = ST_OK;
						we = 1'b1;
						wdata = BINARY_MAX;
					end else if (val < count_limit) begin
						st = ST_OK;
						we = 1'b1;
						wdata = CNT_W'(val + 1'b1);
					end
				end
			end
			OP_DESTROY: begin
				if (ent_ok) begin
					st = ST_OK;
					clr_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_used_q <= '0;
			cnt_used_q <= '0;
			bk_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && set_en) begin
				if (bk_req_s1.sem_kind) begin
					cnt_used_q[flag_idx] <= 1'b1;
				end else begin
					bin_used_q[flag_idx] <= 1'b1;
				end
			end
			if (adv && clr_en) begin
				if (bk_req_s1.sem_kind) begin
					cnt_used_q[flag_idx] <= 1'b0;
				end else begin
					bin_used_q[flag_idx] <= 1'b0;
				end
			end
			if (q_pop) begin
				bk_valid_s1 <= 1'b1;
			end else if (adv) begin
				bk_valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A value written in the same cycle as the next read of that entry is
	// forwarded, since the memory returns the old contents.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			bk_req_s1 <= q_req;
			byp_s1 <= ram_we && (waddr == raddr);
			byp_data_s1 <= wdata;
		end
		if (adv) begin
			status_q <= st;
			index_q <= idx_out;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign allocated_index = index_q;

	`STU_ASSERT_NEXT(a_create_adds_one, adv && set_en, $countones({cnt_used_q, bin_used_q}) == $past($countones({cnt_used_q, bin_used_q})) + 1, "create did not take exactly one entry")
	`STU_ASSERT_NEXT(a_destroy_frees_one, adv && clr_en, $countones({cnt_used_q, bin_used_q}) + 1 == $past($countones({cnt_used_q, bin_used_q})), "destroy did not free exactly one entry")
	`STU_ASSERT_NEXT(a_flags_hold, !adv, $stable({cnt_used_q, bin_used_q}), "in-use flags changed without a request")
	`STU_ASSERT(a_index_zero_on_fail, out_valid_q && (status_q != ST_OK) |-> (index_q == '0), "index reported on a failed request")

endmodule
`default_nettype wire

// ----- hw/rtl/semaphore_table_unit_top.sv -----
// Semaphore table unit: a binary and a counting semaphore table of NUM_SEMS
// entries each, driven one request per transfer and answering with exactly one
// result transfer per request, in order. A request passes an input register
// that classifies it (range and initial count checks), a two-entry queue, and
// an execute stage that reads the entry's count from a small memory, applies
// create, wait, post or destroy, and loads the output register. The unit
// sustains one request per cycle while out_stall stays low; the execute
// stage, which reads, updates and writes one entry per cycle with forwarding
// between neighboring requests, sets that figure. Both tables are empty after
// reset with no clearing pass, because the in-use flags live in flip-flops.
// count_limit may be written only while the unit is idle.
`default_nettype none
module semaphore_table_unit_top #(
	parameter int unsigned NUM_SEMS = stu_pkg::NUM_SEMS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         count_limit_wr_en,
	input  wire logic [stu_pkg::CNT_W-1:0]    count_limit_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   operation,
	input  wire logic                         sem_kind,
	input  wire logic [stu_pkg::ID_W-1:0]     sem_id,
	input  wire logic [stu_pkg::CNT_W-1:0]    initial_count,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [stu_pkg::STATUS_W-1:0]      status,
	output logic [stu_pkg::ID_W-1:0]          allocated_index
);
	import stu_pkg::*;

	// The configured limit feeds the create check in the front end and the
	// post check in the back end.
	logic [CNT_W-1:0] count_limit_q;

	logic     push;
	stu_req_t push_req;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;
	stu_req_t q_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_limit_q <= COUNT_LIMIT_RST;
		end else if (count_limit_wr_en) begin
			count_limit_q <= count_limit_wr_data;
		end
	end

	// The front end takes a request transfer whenever its register is empty
	// or moving into the queue.
	stu_front #(
		.NUM_SEMS(NUM_SEMS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.count_limit  (count_limit_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.sem_kind     (sem_kind),
		.sem_id       (sem_id),
		.initial_count(initial_count),
		.push         (push),
		.push_req     (push_req),
		.full         (q_full)
	);

	// The queue lets the front end keep accepting while results back up.
	stu_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.pop_req (q_req)
	);

	// The back end owns both tables and the result register.
	stu_back #(
		.NUM_SEMS(NUM_SEMS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.count_limit    (count_limit_q),
		.q_valid        (q_valid),
		.q_req          (q_req),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.allocated_index(allocated_index)
	);

endmodule
`default_nettype wire

// ----- dv/semaphore_table_unit_top_test.sv -----
`default_nettype none
module semaphore_table_unit_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stu_pkg::*;

	localparam int unsigned SEM_ENTRIES = NUM_SEMS_DEF;
	localparam int unsigned SLOT_W = (SEM_ENTRIES > 1) ? $clog2(SEM_ENTRIES) : 1;
	localparam int unsigned LONG_HOLD = 60;
	localparam int unsigned NUM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 210;

	// One request as it is presented on the input channel.
	typedef struct packed {
		op_t              op;
		logic             kind;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] init;
	} sem_request_t;

	// One result as it is expected on the output channel.
	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] grant;
	} sem_result_t;

	// Clock and reset. Every block input starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic count_limit_wr_en = 1'b0;
	logic [CNT_W-1:0] count_limit_wr_data = '0;
	logic in_valid = 1'b0;
	logic [1:0] operation = '0;
	logic sem_kind = 1'b0;
	logic [ID_W-1:0] sem_id = '0;
	logic [CNT_W-1:0] initial_count = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] allocated_index;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	semaphore_table_unit_top uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.count_limit_wr_en   (count_limit_wr_en),
		.count_limit_wr_data (count_limit_wr_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.operation           (operation),
		.sem_kind            (sem_kind),
		.sem_id              (sem_id),
		.initial_count       (initial_count),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.allocated_index     (allocated_index)
	);

	// Shadow copy of both tables, indexed by sem_kind (0 binary, 1 counting).
	// A binary entry keeps its value in the low bit of the count.
	bit in_use [2][SEM_ENTRIES];
	logic [CNT_W-1:0] sem_count [2][SEM_ENTRIES];
	logic [CNT_W-1:0] limit_model = COUNT_LIMIT_RST;

	sem_request_t pending_requests[$];
	sem_result_t expected_replies[$];

	int unsigned queued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned fail_count = 0;
	int unsigned n_success = 0;
	int unsigned n_error = 0;
	int unsigned n_block = 0;
	int unsigned n_limits = 0;

	// Idle controls, set per phase by the sequence below.
	int unsigned tx_gap_max = 0;
	int unsigned rx_stall_max = 0;
	int unsigned hold_requests = 0;

	// Handshake flags that the monitor sets at each rising edge for the
	// processes that drive inputs at the following falling edge.
	bit req_taken = 1'b0;
	bit res_taken = 1'b0;

	// Applies one request to the shadow tables and returns its result. A
	// create ignores sem_id and takes the lowest free entry; all other
	// operations need an id inside the table and an entry that is in use.
	function automatic sem_result_t apply_request(sem_request_t r);
		sem_result_t res;
		logic [CNT_W-1:0] ceiling;
		logic [SLOT_W-1:0] slot;
		bit found;
		res.status = ST_ERR;
		res.grant = '0;
		found = 1'b0;
		slot = r.id[SLOT_W-1:0];
		if (r.op == OP_CREATE) begin
			ceiling = r.kind ? limit_model : BINARY_MAX;
			if (r.init <= ceiling) begin
				for (int i = 0; i < SEM_ENTRIES; i++) begin
					if (!found && !in_use[r.kind][i]) begin
						found = 1'b1;
						in_use[r.kind][i] = 1'b1;
						sem_count[r.kind][i] = r.init;
						res.status = ST_OK;
						res.grant = ID_W'(i);
					end
				end
			end
		end else if (r.id < SEM_ENTRIES && in_use[r.kind][slot]) begin
			case (r.op)
				OP_WAIT: begin
					if (sem_count[r.kind][slot] != '0) begin
						sem_count[r.kind][slot] = sem_count[r.kind][slot] - 1'b1;
						res.status = ST_OK;
					end else begin
						res.status = ST_BLOCK;
					end
				end
				OP_POST: begin
					if (!r.kind) begin
						// An extra post on a binary semaphore is absorbed.
						sem_count[r.kind][slot] = BINARY_MAX;
						res.status = ST_OK;
					end else if (sem_count[r.kind][slot] < limit_model) begin
						sem_count[r.kind][slot] = sem_count[r.kind][slot] + 1'b1;
						res.status = ST_OK;
					end
				end
				default: begin
					in_use[r.kind][slot] = 1'b0;
					sem_count[r.kind][slot] = '0;
					res.status = ST_OK;
				end
			endcase
		end
		return res;
	endfunction

	// Draws one random request. The mix selects the balance of operations:
	// 0 balanced, 1 mostly creates so the tables fill up, 2 mostly destroys
	// and waits so they drain and counts reach zero.
	function automatic sem_request_t draw_request(int unsigned mix);
		sem_request_t r;
		int unsigned roll;
		int unsigned c_w;
		int unsigned w_w;
		int unsigned p_w;
		c_w = (mix == 1) ? 50 : (mix == 2) ? 15 : 30;
		w_w = (mix == 2) ? 30 : (mix == 1) ? 20 : 25;
		p_w = (mix == 1) ? 20 : (mix == 2) ? 20 : 25;
		roll = $urandom_range(0, 99);
		if (roll < c_w)
			r.op = OP_CREATE;
		else if (roll < c_w + w_w)
			r.op = OP_WAIT;
		else if (roll < c_w + w_w + p_w)
			r.op = OP_POST;
		else
			r.op = OP_DESTROY;
		r.kind = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 88)
			r.id = ID_W'($urandom_range(0, SEM_ENTRIES - 1));
		else
			r.id = ID_W'($urandom_range(SEM_ENTRIES, (1 << ID_W) - 1));
		roll = $urandom_range(0, 99);
		if (r.op != OP_CREATE || roll >= 75)
			r.init = CNT_W'($urandom_range(0, 255));
		else if (!r.kind)
			r.init = CNT_W'($urandom_range(0, 1));
		else if (roll < 45)
			r.init = CNT_W'($urandom_range(0, 3));
		else
			r.init = CNT_W'($urandom_range(0, limit_model));
		return r;
	endfunction

	// Sender. A presented transfer holds until the monitor sees it taken;
	// after each item a random number of idle cycles follows.
	always @(negedge clk) begin
		int unsigned gap_left;
		sem_request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else if (in_valid && !req_taken) begin
			// Stalled: keep the payload stable.
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_requests.size() > 0) begin
			r = pending_requests.pop_front();
			operation <= r.op;
			sem_kind <= r.kind;
			sem_id <= r.id;
			initial_count <= r.init;
			in_valid <= 1'b1;
			gap_left = $urandom_range(0, tx_gap_max);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver. After each result it draws a stall of its own; a long hold,
	// when requested, is counted down here one cycle at a time.
	always @(negedge clk) begin
		int unsigned hold_grants;
		int unsigned hold_left;
		int unsigned stall_left;
		if (!arst_n) begin
			hold_grants = 0;
			hold_left = 0;
			stall_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (hold_requests != hold_grants) begin
				hold_grants++;
				hold_left = LONG_HOLD;
			end
			if (res_taken)
				stall_left = $urandom_range(0, rx_stall_max);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor. Each input transfer is predicted as it is taken, and each
	// result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		sem_request_t r;
		sem_result_t want;
		req_taken = 1'b0;
		res_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				req_taken = 1'b1;
				r.op = op_t'(operation);
				r.kind = sem_kind;
				r.id = sem_id;
				r.init = initial_count;
				expected_replies.push_back(apply_request(r));
				accepted_count++;
			end
			if (out_valid && !out_stall) begin
				res_taken = 1'b1;
				if (expected_replies.size() == 0) begin
					$error("result transfer with no request outstanding: status %0d",
						status);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						fail_count++;
					end
					if (allocated_index !== want.grant) begin
						$error("allocated_index mismatch: expected %0d, actual %0d",
							want.grant, allocated_index);
						fail_count++;
					end
					case (want.status)
						ST_OK: n_success++;
						ST_BLOCK: n_block++;
						default: n_error++;
					endcase
				end
			end
		end
	end

	task automatic add_request(op_t op, logic kind, int unsigned id, int unsigned init);
		sem_request_t r;
		r.op = op;
		r.kind = kind;
		r.id = ID_W'(id);
		r.init = CNT_W'(init);
		pending_requests.push_back(r);
		queued_count++;
	endtask

	// Returns once every queued request has been taken and answered.
	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (accepted_count != queued_count || expected_replies.size() != 0);
	endtask

	// The unit is idle whenever this is called, so the shadow limit changes
	// together with the register.
	task automatic write_limit(logic [CNT_W-1:0] value);
		@(negedge clk);
		count_limit_wr_en <= 1'b1;
		count_limit_wr_data <= value;
		@(negedge clk);
		count_limit_wr_en <= 1'b0;
		limit_model = value;
		n_limits++;
	endtask

	// Test sequence: directed cases first, then random phases that each set
	// a new limit, an operation mix and idle behavior on both sides.
	initial begin
		logic [CNT_W-1:0] phase_limit [NUM_PHASES];
		int unsigned phase_mix [NUM_PHASES];
		int unsigned phase_tx [NUM_PHASES];
		int unsigned phase_rx [NUM_PHASES];
		sem_request_t r;
		phase_limit = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd200, 8'd2, 8'd255, 8'd128};
		phase_mix = '{1, 0, 2, 1, 0, 1, 2, 0};
		phase_tx = '{6, 0, 6, 3, 6, 0, 6, 2};
		phase_rx = '{6, 6, 0, 6, 3, 0, 6, 6};
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset limit of 255. Operations on unused or
		// out-of-range entries fail, a binary create above 1 fails, and the
		// binary post on a value of 1 is absorbed with success.
		add_request(OP_WAIT, 1'b0, 0, 0);
		add_request(OP_POST, 1'b1, 63, 255);
		add_request(OP_DESTROY, 1'b0, SEM_ENTRIES, 0);
		add_request(OP_CREATE, 1'b0, 0, 2);
		add_request(OP_CREATE, 1'b0, 0, 1);
		add_request(OP_CREATE, 1'b0, 0, 0);
		add_request(OP_WAIT, 1'b0, 1, 0);
		add_request(OP_POST, 1'b0, 0, 0);
		add_request(OP_WAIT, 1'b0, 0, 0);
		add_request(OP_WAIT, 1'b0, 0, 0);
		add_request(OP_POST, 1'b0, 1, 0);
		// Counting table: create at the limit, post at the limit fails.
		add_request(OP_CREATE, 1'b1, 0, 255);
		add_request(OP_POST, 1'b1, 0, 0);
		add_request(OP_WAIT, 1'b1, 0, 0);
		add_request(OP_POST, 1'b1, 0, 0);
		add_request(OP_CREATE, 1'b1, 0, 0);
		add_request(OP_WAIT, 1'b1, 1, 0);
		add_request(OP_DESTROY, 1'b1, 1, 0);
		add_request(OP_DESTROY, 1'b1, 1, 0);
		// Create ignores sem_id and reuses the freed entry.
		add_request(OP_CREATE, 1'b1, 63, 0);
		wait_for_drain();

		// A limit of zero: only a zero create passes, and every counting
		// post fails, including the one on an entry holding 255.
		write_limit(8'd0);
		@(posedge clk);
		add_request(OP_CREATE, 1'b1, 0, 0);
		add_request(OP_CREATE, 1'b1, 0, 1);
		add_request(OP_POST, 1'b1, 2, 0);
		add_request(OP_POST, 1'b1, 0, 0);
		wait_for_drain();

		// Random phases. Each one is split in two halves with a full drain
		// between them, so the sender also pauses until nothing is pending.
		// In the first half the receiver holds off for a long stretch while
		// the sender keeps offering, which backs the unit up to its input.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_limit(phase_limit[p]);
			tx_gap_max = phase_tx[p];
			rx_stall_max = phase_rx[p];
			for (int half = 0; half < 2; half++) begin
				@(posedge clk);
				for (int k = 0; k < PHASE_ITEMS / 2; k++) begin
					r = draw_request(phase_mix[p]);
					add_request(r.op, r.kind, r.id, r.init);
				end
				if (half == 0)
					hold_requests++;
				wait_for_drain();
			end
		end

		$display("Ran %0d requests over %0d limit settings with idle gaps, long output holds",
			accepted_count, n_limits);
		$display("and full drains: %0d success, %0d error, %0d would block.",
			n_success, n_error, n_block);
		if (fail_count == 0 && accepted_count == queued_count)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#3ms;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/stu_pkg.sv
hw/rtl/stu_ram.sv
hw/rtl/stu_fifo.sv
hw/rtl/stu_front.sv
hw/rtl/stu_back.sv
hw/rtl/semaphore_table_unit_top.sv
dv/semaphore_table_unit_top_test.sv
